/* hdl/lfucl_pkg.sv */
// shared types and constants for the lfu cache lookup/replace unit
package lfucl_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  // answer of a get that misses
  localparam logic [VAL_W-1:0] VAL_MISS = '1;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_UPD,
    ST_UPD_END,
    ST_FINISH,
    ST_RESP
  } state_t;

  // one entry read coming back from the stores
  typedef struct packed {
    logic vld;
    logic ent_valid;
  } beat_t;

  typedef struct packed {
    logic found;
    logic victim_found;
    logic free_found;
  } scan_flags_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } result_t;

endpackage

/* hdl/lfucl_store.sv */
// entry stores: key, value, use count and recency rank memories
module lfucl_store #(
  parameter int MAX_ENTRIES = lfucl_pkg::MAX_ENTRIES_DEF,
  parameter int COUNT_WIDTH = lfucl_pkg::COUNT_WIDTH_DEF,
  parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                       clk,
  input  logic [IDX_W-1:0]           rd_addr,
  output logic [lfucl_pkg::KEY_W-1:0] rd_key,
  output logic [lfucl_pkg::VAL_W-1:0] rd_value,
  output logic [COUNT_WIDTH-1:0]     rd_count,
  output logic [IDX_W-1:0]           rd_rank,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic                       wr_key_en,
  input  logic [lfucl_pkg::KEY_W-1:0] wr_key,
  input  logic                       wr_value_en,
  input  logic [lfucl_pkg::VAL_W-1:0] wr_value,
  input  logic                       wr_count_en,
  input  logic [COUNT_WIDTH-1:0]     wr_count,
  input  logic                       rk_wr_en,
  input  logic [IDX_W-1:0]           rk_wr_addr,
  input  logic [IDX_W-1:0]           rk_wr_data
);

  logic [lfucl_pkg::KEY_W-1:0] key_mem   [MAX_ENTRIES];
  logic [lfucl_pkg::VAL_W-1:0] value_mem [MAX_ENTRIES];
  logic [COUNT_WIDTH-1:0]     count_mem [MAX_ENTRIES];
  logic [IDX_W-1:0]           rank_mem  [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_value_en) begin
      value_mem[wr_addr] <= wr_value;
    end
    if (wr_count_en) begin
      count_mem[wr_addr] <= wr_count;
    end
    if (rk_wr_en) begin
      rank_mem[rk_wr_addr] <= rk_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_key   <= key_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
    rd_count <= count_mem[rd_addr];
    rd_rank  <= rank_mem[rd_addr];
  end

endmodule

/* hdl/lfucl_scan.sv */
// shared compare unit: folds one entry per cycle into match, victim, free-slot and occupancy results
module lfucl_scan #(
  parameter int MAX_ENTRIES = lfucl_pkg::MAX_ENTRIES_DEF,
  parameter int COUNT_WIDTH = lfucl_pkg::COUNT_WIDTH_DEF,
  parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  parameter int OCC_W       = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  lfucl_pkg::beat_t            beat,
  input  logic [IDX_W-1:0]            beat_idx,
  input  logic [lfucl_pkg::KEY_W-1:0] lookup_key,
  input  logic [lfucl_pkg::KEY_W-1:0] rd_key,
  input  logic [lfucl_pkg::VAL_W-1:0] rd_value,
  input  logic [COUNT_WIDTH-1:0]      rd_count,
  input  logic [IDX_W-1:0]            rd_rank,
  output lfucl_pkg::scan_flags_t      flags,
  output logic [IDX_W-1:0]            hit_idx,
  output logic [IDX_W-1:0]            hit_rank,
  output logic [COUNT_WIDTH-1:0]      hit_count,
  output logic [lfucl_pkg::VAL_W-1:0] hit_value,
  output logic [IDX_W-1:0]            victim_idx,
  output logic [IDX_W-1:0]            victim_rank,
  output logic [lfucl_pkg::KEY_W-1:0] victim_key,
  output logic [IDX_W-1:0]            free_idx,
  output logic [OCC_W-1:0]            occ
);

  lfucl_pkg::scan_flags_t flags_r, flags_nxt;
  logic [OCC_W-1:0]       occ_r, occ_nxt;

  logic [IDX_W-1:0]            hit_idx_r, hit_rank_r;
  logic [COUNT_WIDTH-1:0]      hit_count_r;
  logic [lfucl_pkg::VAL_W-1:0] hit_value_r;
  logic [IDX_W-1:0]            v_idx_r, v_rank_r;
  logic [COUNT_WIDTH-1:0]      v_count_r;
  logic [lfucl_pkg::KEY_W-1:0] v_key_r;
  logic [IDX_W-1:0]            free_idx_r;

  logic live, take_match, take_victim, take_free;

  always_comb begin
    live        = beat.vld && beat.ent_valid;
    take_match  = live && (rd_key == lookup_key);
    // lowest count wins, oldest rank breaks a tie
    take_victim = live && (!flags_r.victim_found || (rd_count < v_count_r) ||
                           ((rd_count == v_count_r) && (rd_rank > v_rank_r)));
    take_free   = beat.vld && !beat.ent_valid && !flags_r.free_found;

    flags_nxt = flags_r;
    if (take_match) begin
      flags_nxt.found = 1'b1;
    end
    if (take_victim) begin
      flags_nxt.victim_found = 1'b1;
    end
    if (take_free) begin
      flags_nxt.free_found = 1'b1;
    end
    occ_nxt = occ_r + {{(OCC_W-1){1'b0}}, live};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      flags_r <= '0;
      occ_r   <= '0;
    end else begin
      flags_r <= flags_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_match) begin
      hit_idx_r   <= beat_idx;
      hit_rank_r  <= rd_rank;
      hit_count_r <= rd_count;
      hit_value_r <= rd_value;
    end
    if (take_victim) begin
      v_idx_r   <= beat_idx;
      v_rank_r  <= rd_rank;
      v_count_r <= rd_count;
      v_key_r   <= rd_key;
    end
    if (take_free) begin
      free_idx_r <= beat_idx;
    end
  end

  assign flags       = flags_r;
  assign occ         = occ_r;
  assign hit_idx     = hit_idx_r;
  assign hit_rank    = hit_rank_r;
  assign hit_count   = hit_count_r;
  assign hit_value   = hit_value_r;
  assign victim_idx  = v_idx_r;
  assign victim_rank = v_rank_r;
  assign victim_key  = v_key_r;
  assign free_idx    = free_idx_r;

endmodule

/* hdl/lfucl_ctrl.sv */
// sequencer: scan pass, decision, rank update pass and entry write for one word
module lfucl_ctrl #(
  parameter int MAX_ENTRIES = lfucl_pkg::MAX_ENTRIES_DEF,
  parameter int COUNT_WIDTH = lfucl_pkg::COUNT_WIDTH_DEF,
  parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  parameter int OCC_W       = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [lfucl_pkg::KEY_W-1:0] in_key,
  input  logic [lfucl_pkg::VAL_W-1:0] in_value,
  input  logic [lfucl_pkg::CAP_W-1:0] cap,
  output logic                        res_valid,
  input  logic                        res_ready,
  output lfucl_pkg::result_t          res,
  // entry stores
  output logic [IDX_W-1:0]            rd_addr,
  input  logic [IDX_W-1:0]            rd_rank,
  output logic [IDX_W-1:0]            wr_addr,
  output logic                        wr_key_en,
  output logic [lfucl_pkg::KEY_W-1:0] wr_key,
  output logic                        wr_value_en,
  output logic [lfucl_pkg::VAL_W-1:0] wr_value,
  output logic                        wr_count_en,
  output logic [COUNT_WIDTH-1:0]      wr_count,
  output logic                        rk_wr_en,
  output logic [IDX_W-1:0]            rk_wr_addr,
  output logic [IDX_W-1:0]            rk_wr_data,
  // compare unit
  output logic                        scan_clr,
  output lfucl_pkg::beat_t            beat,
  output logic [IDX_W-1:0]            beat_idx,
  output logic [lfucl_pkg::KEY_W-1:0] lookup_key,
  input  lfucl_pkg::scan_flags_t      flags,
  input  logic [IDX_W-1:0]            hit_idx,
  input  logic [IDX_W-1:0]            hit_rank,
  input  logic [COUNT_WIDTH-1:0]      hit_count,
  input  logic [lfucl_pkg::VAL_W-1:0] hit_value,
  input  logic [IDX_W-1:0]            victim_idx,
  input  logic [IDX_W-1:0]            victim_rank,
  input  logic [lfucl_pkg::KEY_W-1:0] victim_key,
  input  logic [IDX_W-1:0]            free_idx,
  input  logic [OCC_W-1:0]            occ
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
  localparam int CMP_W = (OCC_W > lfucl_pkg::CAP_W) ? OCC_W : lfucl_pkg::CAP_W;
  localparam logic [CMP_W-1:0] ENT_CMP = CMP_W'(MAX_ENTRIES);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

  lfucl_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;

  lfucl_pkg::cmd_t             cmd_r;
  logic [lfucl_pkg::KEY_W-1:0] key_r;
  logic [lfucl_pkg::VAL_W-1:0] val_r;
  lfucl_pkg::result_t          res_r, res_nxt;
  logic [IDX_W-1:0]            target_r, target_nxt;
  logic [IDX_W-1:0]            victim_r, victim_nxt;
  logic [IDX_W-1:0]            ref_rank_r, ref_rank_nxt;
  logic [COUNT_WIDTH-1:0]      new_count_r, new_count_nxt;
  logic                        hit_mode_r, hit_mode_nxt;
  logic                        evict_r, evict_nxt;

  logic                        issue, accept, ent_valid;
  logic [CMP_W-1:0]            cap_ext, cap_eff, occ_ext;
  logic                        do_evict;
  logic [IDX_W-1:0]            rank_inc;

  always_comb begin
    accept    = (state_r == lfucl_pkg::ST_IDLE) && in_valid;
    issue     = (state_r == lfucl_pkg::ST_SCAN) || (state_r == lfucl_pkg::ST_UPD);
    ent_valid = valid_r[rd_idx_r];
    rank_inc  = rd_rank + IDX_W'(1);

    cap_ext = CMP_W'(cap);
    cap_eff = (cap_ext > ENT_CMP) ? ENT_CMP : cap_ext;
    occ_ext = CMP_W'(occ);
    do_evict = occ_ext >= cap_eff;

    state_nxt     = state_r;
    idx_nxt       = idx_r;
    valid_nxt     = valid_r;
    res_nxt       = res_r;
    target_nxt    = target_r;
    victim_nxt    = victim_r;
    ref_rank_nxt  = ref_rank_r;
    new_count_nxt = new_count_r;
    hit_mode_nxt  = hit_mode_r;
    evict_nxt     = evict_r;

    wr_key_en   = 1'b0;
    wr_value_en = 1'b0;
    wr_count_en = 1'b0;
    res_valid   = 1'b0;

    if (issue) begin
      idx_nxt = idx_r + IDX_W'(1);
    end

    case (state_r)
      lfucl_pkg::ST_IDLE: begin
        idx_nxt = '0;
        if (in_valid) begin
          state_nxt = lfucl_pkg::ST_SCAN;
        end
      end
      lfucl_pkg::ST_SCAN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = lfucl_pkg::ST_SCAN_END;
        end
      end
      lfucl_pkg::ST_SCAN_END: begin
        state_nxt = lfucl_pkg::ST_DECIDE;
      end
      lfucl_pkg::ST_DECIDE: begin
        idx_nxt = '0;
        res_nxt = '0;
        evict_nxt = 1'b0;
        hit_mode_nxt = 1'b0;
        if (cap_eff == '0) begin
          if (cmd_r == lfucl_pkg::CMD_GET) begin
            res_nxt.read_value = lfucl_pkg::VAL_MISS;
          end
          state_nxt = lfucl_pkg::ST_RESP;
        end else if (flags.found) begin
          res_nxt.hit = 1'b1;
          if (cmd_r == lfucl_pkg::CMD_GET) begin
            res_nxt.read_value = hit_value;
          end
          hit_mode_nxt  = 1'b1;
          target_nxt    = hit_idx;
          ref_rank_nxt  = hit_rank;
          new_count_nxt = (hit_count == COUNT_MAX) ? hit_count : hit_count + COUNT_ONE;
          state_nxt     = lfucl_pkg::ST_UPD;
        end else if (cmd_r == lfucl_pkg::CMD_GET) begin
          res_nxt.read_value = lfucl_pkg::VAL_MISS;
          state_nxt = lfucl_pkg::ST_RESP;
        end else begin
          evict_nxt    = do_evict;
          victim_nxt   = victim_idx;
          ref_rank_nxt = victim_rank;
          // lowest free slot once the victim has left
          if (do_evict && (!flags.free_found || (victim_idx < free_idx))) begin
            target_nxt = victim_idx;
          end else begin
            target_nxt = free_idx;
          end
          new_count_nxt       = COUNT_ONE;
          res_nxt.evicted     = do_evict;
          res_nxt.evicted_key = do_evict ? victim_key : '0;
          state_nxt           = lfucl_pkg::ST_UPD;
        end
      end
      lfucl_pkg::ST_UPD: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = lfucl_pkg::ST_UPD_END;
        end
      end
      lfucl_pkg::ST_UPD_END: begin
        state_nxt = lfucl_pkg::ST_FINISH;
      end
      lfucl_pkg::ST_FINISH: begin
        wr_key_en   = !hit_mode_r;
        wr_value_en = (cmd_r == lfucl_pkg::CMD_PUT);
        wr_count_en = 1'b1;
        if (evict_r) begin
          valid_nxt[victim_r] = 1'b0;
        end
        valid_nxt[target_r] = 1'b1;
        state_nxt = lfucl_pkg::ST_RESP;
      end
      lfucl_pkg::ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = lfucl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lfucl_pkg::ST_IDLE;
      end
    endcase
  end

  // rank rewrite, one entry per cycle behind the read
  always_comb begin
    rk_wr_en   = 1'b0;
    rk_wr_data = rd_rank;
    if (rd_vld_r && ((state_r == lfucl_pkg::ST_UPD) || (state_r == lfucl_pkg::ST_UPD_END))) begin
      if (rd_idx_r == target_r) begin
        rk_wr_en   = 1'b1;
        rk_wr_data = '0;
      end else if (ent_valid && !(evict_r && (rd_idx_r == victim_r))) begin
        rk_wr_en = 1'b1;
        if (hit_mode_r) begin
          rk_wr_data = (rd_rank < ref_rank_r) ? rank_inc : rd_rank;
        end else begin
          // insert: ranks shift back; after an evict, ranks behind the victim close up and shift back
          rk_wr_data = (evict_r && (rd_rank > ref_rank_r)) ? rd_rank : rank_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lfucl_pkg::ST_IDLE;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      valid_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= issue;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= idx_r;
    res_r       <= res_nxt;
    target_r    <= target_nxt;
    victim_r    <= victim_nxt;
    ref_rank_r  <= ref_rank_nxt;
    new_count_r <= new_count_nxt;
    hit_mode_r  <= hit_mode_nxt;
    evict_r     <= evict_nxt;
    if (accept) begin
      cmd_r <= lfucl_pkg::cmd_t'(in_cmd);
      key_r <= in_key;
      val_r <= in_value;
    end
  end

  assign in_ready   = (state_r == lfucl_pkg::ST_IDLE);
  assign res        = res_r;
  assign rd_addr    = idx_r;
  assign wr_addr    = target_r;
  assign wr_key     = key_r;
  assign wr_value   = val_r;
  assign wr_count   = new_count_r;
  assign rk_wr_addr = rd_idx_r;
  assign scan_clr   = accept;
  assign beat.vld   = rd_vld_r &&
                      ((state_r == lfucl_pkg::ST_SCAN) || (state_r == lfucl_pkg::ST_SCAN_END));
  assign beat.ent_valid = ent_valid;
  assign beat_idx   = rd_idx_r;
  assign lookup_key = key_r;

endmodule

/* hdl/lfu_cache_lookup_replace_unit.sv */
// Fully associative key/value cache with least-frequently-used replacement and
// least-recently-used tie break. Each input word is a get or a put; each gives
// exactly one result word. Entries live in single-port-read memories that a
// sequencer walks one entry per cycle: a scan pass finds the matching key, the
// occupancy, the first free slot and the eviction victim, and, for a hit or a put
// that inserts, a second pass rewrites the recency ranks. A get that misses (or any
// word while capacity is zero) skips the second pass and the entry write. A new
// word is taken while the previous result still waits in the output register.
// Capacity writes above MAX_ENTRIES act as MAX_ENTRIES. No clearing pass is run
// after reset.
module lfu_cache_lookup_replace_unit #(
  parameter int MAX_ENTRIES = lfucl_pkg::MAX_ENTRIES_DEF,
  parameter int COUNT_WIDTH = lfucl_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // lookup_key[31:0], write_value[63:32]
  input  logic        in_tuser,    // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // read_value[31:0], evicted_key[63:32]
  output logic [1:0]  out_tuser,   // hit[0], evicted[1]
  input  logic        cfg_wr_en,
  input  logic [lfucl_pkg::CAP_W-1:0] cfg_wr_data  // active_capacity
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);

  logic [lfucl_pkg::CAP_W-1:0] cap_r;

  logic               res_valid, res_ready;
  lfucl_pkg::result_t res;
  lfucl_pkg::result_t out_r;
  logic               out_vld_r;

  logic [IDX_W-1:0]            rd_addr, rd_rank, wr_addr, rk_wr_addr, rk_wr_data;
  logic [lfucl_pkg::KEY_W-1:0] rd_key, wr_key, lookup_key, victim_key;
  logic [lfucl_pkg::VAL_W-1:0] rd_value, wr_value, hit_value;
  logic [COUNT_WIDTH-1:0]      rd_count, wr_count, hit_count;
  logic                        wr_key_en, wr_value_en, wr_count_en, rk_wr_en;

  logic                   scan_clr;
  lfucl_pkg::beat_t       beat;
  logic [IDX_W-1:0]       beat_idx;
  lfucl_pkg::scan_flags_t flags;
  logic [IDX_W-1:0]       hit_idx, hit_rank, victim_idx, victim_rank, free_idx;
  logic [OCC_W-1:0]       occ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lfucl_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // output register parts the result side from the sequencer
  assign res_ready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_ready) begin
      out_vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.evicted_key, out_r.read_value};
  assign out_tuser  = {out_r.evicted, out_r.hit};

  lfucl_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W),
    .OCC_W       (OCC_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_cmd      (in_tuser),
    .in_key      (in_tdata[31:0]),
    .in_value    (in_tdata[63:32]),
    .cap         (cap_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .rd_addr     (rd_addr),
    .rd_rank     (rd_rank),
    .wr_addr     (wr_addr),
    .wr_key_en   (wr_key_en),
    .wr_key      (wr_key),
    .wr_value_en (wr_value_en),
    .wr_value    (wr_value),
    .wr_count_en (wr_count_en),
    .wr_count    (wr_count),
    .rk_wr_en    (rk_wr_en),
    .rk_wr_addr  (rk_wr_addr),
    .rk_wr_data  (rk_wr_data),
    .scan_clr    (scan_clr),
    .beat        (beat),
    .beat_idx    (beat_idx),
    .lookup_key  (lookup_key),
    .flags       (flags),
    .hit_idx     (hit_idx),
    .hit_rank    (hit_rank),
    .hit_count   (hit_count),
    .hit_value   (hit_value),
    .victim_idx  (victim_idx),
    .victim_rank (victim_rank),
    .victim_key  (victim_key),
    .free_idx    (free_idx),
    .occ         (occ)
  );

  lfucl_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk         (clk),
    .rd_addr     (rd_addr),
    .rd_key      (rd_key),
    .rd_value    (rd_value),
    .rd_count    (rd_count),
    .rd_rank     (rd_rank),
    .wr_addr     (wr_addr),
    .wr_key_en   (wr_key_en),
    .wr_key      (wr_key),
    .wr_value_en (wr_value_en),
    .wr_value    (wr_value),
    .wr_count_en (wr_count_en),
    .wr_count    (wr_count),
    .rk_wr_en    (rk_wr_en),
    .rk_wr_addr  (rk_wr_addr),
    .rk_wr_data  (rk_wr_data)
  );

  lfucl_scan #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W),
    .OCC_W       (OCC_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .clr         (scan_clr),
    .beat        (beat),
    .beat_idx    (beat_idx),
    .lookup_key  (lookup_key),
    .rd_key      (rd_key),
    .rd_value    (rd_value),
    .rd_count    (rd_count),
    .rd_rank     (rd_rank),
    .flags       (flags),
    .hit_idx     (hit_idx),
    .hit_rank    (hit_rank),
    .hit_count   (hit_count),
    .hit_value   (hit_value),
    .victim_idx  (victim_idx),
    .victim_rank (victim_rank),
    .victim_key  (victim_key),
    .free_idx    (free_idx),
    .occ         (occ)
  );

endmodule

/* tb/lfu_cache_checker.sv */
// checker for the lfu cache unit: mirrors the cache contents and compares every result word
`timescale 1ns / 100ps

module lfu_cache_checker #(
  parameter int MAX_ENTRIES = lfucl_pkg::MAX_ENTRIES_DEF,
  parameter int COUNT_WIDTH = lfucl_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,    // lookup_key[31:0], write_value[63:32]
  input  logic        in_tuser,    // command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,   // read_value[31:0], evicted_key[63:32]
  input  logic [1:0]  out_tuser,   // hit[0], evicted[1]
  input  logic        cfg_wr_en,
  input  logic [lfucl_pkg::CAP_W-1:0] cfg_wr_data,
  output int          outstanding,
  output int          fail_count
);

  localparam logic [COUNT_WIDTH-1:0] USES_MAX = '1;

  logic [lfucl_pkg::CAP_W-1:0] capacity;
  logic                        slot_valid [MAX_ENTRIES];
  logic [lfucl_pkg::KEY_W-1:0] slot_key   [MAX_ENTRIES];
  logic [lfucl_pkg::VAL_W-1:0] slot_value [MAX_ENTRIES];
  logic [COUNT_WIDTH-1:0]      slot_uses  [MAX_ENTRIES];
  int                          slot_age   [MAX_ENTRIES];  // 0 = most recent

  lfucl_pkg::result_t pending_results [$];
  int                 errors = 0;

  // raise the use count (saturating) and move the entry to the front
  task automatic bump_entry(input int e);
    if (slot_uses[e] != USES_MAX)
      slot_uses[e]++;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (slot_valid[i] && i != e && slot_age[i] < slot_age[e])
        slot_age[i]++;
    slot_age[e] = 0;
  endtask

  task automatic cache_access(input lfucl_pkg::cmd_t cmd,
                              input logic [lfucl_pkg::KEY_W-1:0] key,
                              input logic [lfucl_pkg::VAL_W-1:0] val,
                              output lfucl_pkg::result_t res);
    int lim, slot, victim, free_slot, occupancy;
    lim = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity);
    res = '0;
    slot = -1;
    if (lim != 0)
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (slot_valid[i] && slot_key[i] == key)
          slot = i;
    if (cmd == lfucl_pkg::CMD_GET) begin
      if (slot >= 0) begin
        bump_entry(slot);
        res.hit = 1'b1;
        res.read_value = slot_value[slot];
      end else begin
        res.read_value = lfucl_pkg::VAL_MISS;
      end
    end else if (lim != 0) begin
      if (slot >= 0) begin
        slot_value[slot] = val;
        bump_entry(slot);
        res.hit = 1'b1;
      end else begin
        occupancy = 0;
        foreach (slot_valid[i])
          if (slot_valid[i])
            occupancy++;
        if (occupancy >= lim) begin
          // fewest uses first, oldest among equals
          victim = -1;
          for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim])))
              victim = i;
          slot_valid[victim] = 1'b0;
          for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_valid[i] && slot_age[i] > slot_age[victim])
              slot_age[i]--;
          res.evicted = 1'b1;
          res.evicted_key = slot_key[victim];
        end
        free_slot = -1;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
          if (!slot_valid[i])
            free_slot = i;
        if (free_slot >= 0) begin
          for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_valid[i])
              slot_age[i]++;
          slot_valid[free_slot] = 1'b1;
          slot_key[free_slot]   = key;
          slot_value[free_slot] = val;
          slot_uses[free_slot]  = 1;
          slot_age[free_slot]   = 0;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    lfucl_pkg::result_t want, res;
    if (!rst_n) begin
      capacity = lfucl_pkg::CAP_RESET;
      foreach (slot_valid[i])
        slot_valid[i] = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_wr_en)
        capacity = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result word with no access pending: tdata 'h%0h tuser 'h%0h",
                 out_tdata, out_tuser);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_tuser[0]));
          check_field("read_value", want.read_value, out_tdata[31:0]);
          check_field("evicted", 32'(want.evicted), 32'(out_tuser[1]));
          check_field("evicted_key", want.evicted_key, out_tdata[63:32]);
        end
      end
      if (in_tvalid && in_tready) begin
        cache_access(lfucl_pkg::cmd_t'(in_tuser), in_tdata[31:0], in_tdata[63:32], res);
        pending_results.push_back(res);
      end
    end
    outstanding <= pending_results.size();
    fail_count  <= errors;
  end

endmodule

/* tb/tb_lfu_cache_lookup_replace_unit.sv */
// top of the lfu cache unit testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_lfu_cache_lookup_replace_unit;

  // narrow counts so that saturation is reachable within a short run
  localparam int CNT_W   = 4;
  localparam int CNT_MAX = (1 << CNT_W) - 1;

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_tvalid   = 1'b0;
  logic                        in_tready;
  logic [63:0]                 in_tdata    = '0;
  logic                        in_tuser    = 1'b0;
  logic                        out_tvalid;
  logic                        out_tready  = 1'b0;
  logic [63:0]                 out_tdata;
  logic [1:0]                  out_tuser;
  logic                        cfg_wr_en   = 1'b0;
  logic [lfucl_pkg::CAP_W-1:0] cfg_wr_data = '0;

  int outstanding;
  int fail_count;
  int words_sent = 0;
  bit idle_on    = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lfu_cache_lookup_replace_unit #(
    .COUNT_WIDTH(CNT_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  lfu_cache_checker #(
    .COUNT_WIDTH(CNT_W)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .outstanding(outstanding),
    .fail_count (fail_count)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 93)
      return $urandom_range(1, 4);
    return $urandom_range(12, 70);
  endfunction

  task automatic send_word(input lfucl_pkg::cmd_t cmd,
                           input logic [lfucl_pkg::KEY_W-1:0] key,
                           input logic [lfucl_pkg::VAL_W-1:0] val);
    int gap;
    gap = idle_on ? idle_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {val, key};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // stop offering words until every result word is back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_capacity(input logic [lfucl_pkg::CAP_W-1:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off that backs up the input
  initial begin
    int stall_left;
    bit long_hold_done;
    stall_left = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && words_sent >= 150) begin
        long_hold_done = 1'b1;
        stall_left = 500;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [lfucl_pkg::KEY_W-1:0] key_pool [32];
    logic [lfucl_pkg::CAP_W-1:0] phase_caps [10];
    logic [lfucl_pkg::KEY_W-1:0] key;
    logic [lfucl_pkg::VAL_W-1:0] val;
    int pool_size, idx;
    phase_caps = '{5'd16, 5'd31, 5'd4, 5'd1, 5'd0, 5'd2, 5'd16, 5'd8, 5'd17, 5'd3};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset capacity
    send_word(lfucl_pkg::CMD_GET, 32'h0000_0000, 32'h0);          // miss on an empty cache
    send_word(lfucl_pkg::CMD_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
    send_word(lfucl_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
    send_word(lfucl_pkg::CMD_GET, 32'h0000_0000, 32'h1234_5678);
    send_word(lfucl_pkg::CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);  // put hit overwrites
    send_word(lfucl_pkg::CMD_GET, 32'h0000_0000, 32'h0);          // hit that reads all ones
    // run one key's count into saturation and hit it again
    repeat (CNT_MAX + 1)
      send_word(lfucl_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0);

    // disabled cache: stored keys unreadable, put ignored
    drain();
    write_capacity(5'd0);
    send_word(lfucl_pkg::CMD_GET, 32'h0000_0000, 32'h0);
    send_word(lfucl_pkg::CMD_PUT, 32'h0000_1234, 32'h5);

    // capacity below occupancy: evict the least used, then insert
    drain();
    write_capacity(5'd1);
    send_word(lfucl_pkg::CMD_PUT, 32'hA5A5_5A5A, 32'h1);

    foreach (phase_caps[p]) begin
      drain();
      write_capacity(phase_caps[p]);
      idle_on = (p % 3 != 1);
      pool_size = $urandom_range(2, 28);
      foreach (key_pool[i])
        key_pool[i] = $urandom;
      if ($urandom_range(0, 3) == 0) begin
        key_pool[0] = '0;
        key_pool[1] = '1;
      end
      repeat ((phase_caps[p] == 0) ? 20 : 85) begin
        if ($urandom_range(0, 9) == 0) begin
          key = $urandom;
        end else begin
          // skewed toward the front of the pool so use counts spread out
          idx = $urandom_range(0, $urandom_range(0, pool_size - 1));
          key = key_pool[idx];
        end
        case ($urandom_range(0, 15))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = '0;
          3:       val = '1;
          default: val = $urandom;
        endcase
        send_word($urandom_range(0, 1) ? lfucl_pkg::CMD_PUT : lfucl_pkg::CMD_GET, key, val);
      end
    end

    drain();
    repeat (80) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
hdl/lfucl_pkg.sv
hdl/lfucl_store.sv
hdl/lfucl_scan.sv
hdl/lfucl_ctrl.sv
hdl/lfu_cache_lookup_replace_unit.sv
tb/lfu_cache_checker.sv
tb/tb_lfu_cache_lookup_replace_unit.sv
